>>> sv/urg_pkg.sv
`default_nettype none

package urg_pkg;

    // field widths
    localparam int STATE_W     = 64;
    localparam int VERTEX_W    = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int HALF_W      = STATE_W / 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED         = 2'd1;

    // reset values
    localparam logic [VERTEX_W-1:0] VCOUNT_RESET = 32'd1024;
    localparam logic [STATE_W-1:0]  SEED_RESET   = 64'd1;

    // splitmix64 constants
    localparam logic [STATE_W-1:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [STATE_W-1:0] SM_MUL1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [STATE_W-1:0] SM_MUL2  = 64'h94D0_49BB_1331_11EB;
    localparam int SM_SH1 = 30;
    localparam int SM_SH2 = 27;
    localparam int SM_SH3 = 31;

    // multiply partial products and remainder steps
    localparam int PART_W    = 2;
    localparam logic [PART_W-1:0] PART_LO_LO = 2'd0;
    localparam logic [PART_W-1:0] PART_LO_HI = 2'd1;
    localparam logic [PART_W-1:0] PART_LAST  = 2'd2;
    localparam int MOD_STEPS = STATE_W;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_MIX1,
        ST_MUL1,
        ST_MIX2,
        ST_MUL2,
        ST_FINAL,
        ST_MOD,
        ST_SAVE,
        ST_DONE
    } fsm_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_START,
        DP_ADVANCE,
        DP_MIX1,
        DP_MUL1,
        DP_MIX2,
        DP_MUL2,
        DP_FINAL,
        DP_MOD_STEP,
        DP_SAVE_SRC,
        DP_SAVE_DST,
        DP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [PART_W-1:0]   part;
    } dp_cmd_t;

endpackage

`default_nettype wire

>>> sv/urg_req_if.sv
`default_nettype none

interface urg_req_if;
    logic valid;
    logic ready;
    logic last_request;

    modport source (output valid, input ready, output last_request);
    modport sink   (input valid, output ready, input last_request);
endinterface

`default_nettype wire

>>> sv/urg_res_if.sv
`default_nettype none

interface urg_res_if;
    logic                          valid;
    logic                          ready;
    logic [urg_pkg::VERTEX_W-1:0]  source_vertex;
    logic [urg_pkg::VERTEX_W-1:0]  dest_vertex;
    logic                          edge_valid;
    logic                          batch_done;
    logic [urg_pkg::STATE_W-1:0]   state_after;

    modport source (output valid, input ready, output source_vertex, output dest_vertex,
                    output edge_valid, output batch_done, output state_after);
    modport sink   (input valid, output ready, input source_vertex, input dest_vertex,
                    input edge_valid, input batch_done, input state_after);
endinterface

`default_nettype wire

>>> sv/urg_ctrl.sv
`default_nettype none

module urg_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output urg_pkg::dp_cmd_t       cmd
);
    import urg_pkg::*;

    fsm_state_t         state_reg, state_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               second_reg, second_next;
    logic               out_valid_reg, out_valid_next;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = DP_NOP;
        cmd.part       = cnt_reg[PART_W-1:0];
        in_ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op      = DP_START;
                    second_next = 1'b0;
                    state_next  = ST_MIX1;
                end
            end
            ST_ADVANCE:
            begin
                cmd.op      = DP_ADVANCE;
                second_next = 1'b1;
                state_next  = ST_MIX1;
            end
            ST_MIX1:
            begin
                cmd.op     = DP_MIX1;
                cnt_next   = '0;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.op = DP_MUL1;
                if (cnt_reg[PART_W-1:0] == PART_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_MIX2;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MIX2:
            begin
                cmd.op     = DP_MIX2;
                cnt_next   = '0;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.op = DP_MUL2;
                if (cnt_reg[PART_W-1:0] == PART_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FINAL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINAL:
            begin
                cmd.op     = DP_FINAL;
                cnt_next   = '0;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.op = DP_MOD_STEP;
                if (cnt_reg == STEP_W'(MOD_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SAVE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SAVE:
            begin
                if (second_reg)
                begin
                    cmd.op     = DP_SAVE_DST;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = DP_SAVE_SRC;
                    state_next = ST_ADVANCE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = DP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> sv/urg_dp.sv
`default_nettype none

module urg_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire urg_pkg::dp_cmd_t                cmd,
    input  wire logic                            cfg_we,
    input  wire logic [urg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [urg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            last_request,
    output logic [urg_pkg::VERTEX_W-1:0]         source_vertex,
    output logic [urg_pkg::VERTEX_W-1:0]         dest_vertex,
    output logic                                 edge_valid,
    output logic                                 batch_done,
    output logic [urg_pkg::STATE_W-1:0]          state_after
);
    import urg_pkg::*;

    // configuration and generator state
    logic [VERTEX_W-1:0] vcount_reg, vcount_next;
    logic [STATE_W-1:0]  gen_state_reg, gen_state_next;

    // working registers
    logic [STATE_W-1:0]  z_reg, z_next;
    logic [STATE_W-1:0]  acc_reg, acc_next;
    logic [VERTEX_W-1:0] rem_reg, rem_next;
    logic [VERTEX_W-1:0] src_reg, src_next;
    logic [VERTEX_W-1:0] dst_reg, dst_next;
    logic                last_reg, last_next;

    // output register
    logic [VERTEX_W-1:0] out_src_reg, out_src_next;
    logic [VERTEX_W-1:0] out_dst_reg, out_dst_next;
    logic                out_edge_reg, out_edge_next;
    logic                out_last_reg, out_last_next;
    logic [STATE_W-1:0]  out_state_reg, out_state_next;

    logic [STATE_W-1:0]  state_adv;
    logic [STATE_W-1:0]  mul_const;
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [STATE_W-1:0]  product;
    logic [STATE_W-1:0]  acc_sum;
    logic [VERTEX_W:0]   trial;
    logic [VERTEX_W-1:0] rem_final;

    assign state_adv = gen_state_reg + SM_GAMMA;

    // shared 32x32 multiplier, one partial product per cycle
    always_comb
    begin
        mul_const = (cmd.op == DP_MUL2) ? SM_MUL2 : SM_MUL1;
        case (cmd.part)
            PART_LO_LO:
            begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = mul_const[HALF_W-1:0];
            end
            PART_LO_HI:
            begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = mul_const[STATE_W-1:HALF_W];
            end
            default:
            begin
                mul_a = z_reg[STATE_W-1:HALF_W];
                mul_b = mul_const[HALF_W-1:0];
            end
        endcase
        product = STATE_W'(mul_a) * STATE_W'(mul_b);
        if (cmd.part == PART_LO_LO)
        begin
            acc_sum = product;
        end
        else
        begin
            acc_sum = acc_reg + {product[HALF_W-1:0], {HALF_W{1'b0}}};
        end
    end

    // restoring remainder step, one dividend bit per cycle
    assign trial     = {rem_reg, z_reg[STATE_W-1]};
    assign rem_final = (vcount_reg == '0) ? '0 : rem_reg;

    // next values
    always_comb
    begin
        vcount_next    = vcount_reg;
        gen_state_next = gen_state_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        last_next      = last_reg;
        out_src_next   = out_src_reg;
        out_dst_next   = out_dst_reg;
        out_edge_next  = out_edge_reg;
        out_last_next  = out_last_reg;
        out_state_next = out_state_reg;

        case (cmd.op)
            DP_START:
            begin
                last_next      = last_request;
                gen_state_next = state_adv;
                z_next         = state_adv;
            end
            DP_ADVANCE:
            begin
                gen_state_next = state_adv;
                z_next         = state_adv;
            end
            DP_MIX1:
            begin
                z_next = z_reg ^ (z_reg >> SM_SH1);
            end
            DP_MUL1, DP_MUL2:
            begin
                acc_next = acc_sum;
                if (cmd.part == PART_LAST)
                begin
                    z_next = acc_sum;
                end
            end
            DP_MIX2:
            begin
                z_next = z_reg ^ (z_reg >> SM_SH2);
            end
            DP_FINAL:
            begin
                z_next   = z_reg ^ (z_reg >> SM_SH3);
                rem_next = '0;
            end
            DP_MOD_STEP:
            begin
                z_next = z_reg << 1;
                if (trial >= {1'b0, vcount_reg})
                begin
                    rem_next = VERTEX_W'(trial - {1'b0, vcount_reg});
                end
                else
                begin
                    rem_next = trial[VERTEX_W-1:0];
                end
            end
            DP_SAVE_SRC:
            begin
                src_next = rem_final;
            end
            DP_SAVE_DST:
            begin
                dst_next = rem_final;
            end
            DP_LOAD_OUT:
            begin
                out_src_next   = src_reg;
                out_dst_next   = dst_reg;
                out_edge_next  = (src_reg != dst_reg);
                out_last_next  = last_reg;
                out_state_next = gen_state_reg;
            end
            default:
            begin
            end
        endcase

        // register writes must arrive only while idle; the block does not enforce this
        if (cfg_we)
        begin
            if (cfg_index == CFG_VERTEX_COUNT)
            begin
                vcount_next = cfg_data[VERTEX_W-1:0];
            end
            else if (cfg_index == CFG_SEED)
            begin
                gen_state_next = cfg_data[STATE_W-1:0];
            end
        end
    end

    // configuration and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VCOUNT_RESET;
            gen_state_reg <= SEED_RESET;
        end
        else
        begin
            vcount_reg    <= vcount_next;
            gen_state_reg <= gen_state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        z_reg         <= z_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        last_reg      <= last_next;
        out_src_reg   <= out_src_next;
        out_dst_reg   <= out_dst_next;
        out_edge_reg  <= out_edge_next;
        out_last_reg  <= out_last_next;
        out_state_reg <= out_state_next;
    end

    assign source_vertex = out_src_reg;
    assign dest_vertex   = out_dst_reg;
    assign edge_valid    = out_edge_reg;
    assign batch_done    = out_last_reg;
    assign state_after   = out_state_reg;

endmodule

`default_nettype wire

>>> sv/uniform_random_edge_generator.sv
`default_nettype none

// Random edge generator on a 64-bit splitmix64 state. Each transfer on req
// draws two outputs, reduces each modulo vertex_count and returns source and
// destination vertex, edge_valid (cleared for a self-loop or a zero vertex
// count), the echoed batch mark and the advanced state. Writing the seed
// register loads the generator state at once. Each draw runs the mixing
// steps through one shared 32x32 multiplier (three partial products per
// 64-bit multiply) and then a one-bit-per-cycle remainder unit over the 64
// bits of the mixed value. After both draws the result moves into the output
// register once that register is free. The next request is taken while a
// finished result still waits on res.
module uniform_random_edge_generator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    urg_req_if.sink                              req,
    urg_res_if.source                            res,
    input  wire logic                            cfg_we,
    input  wire logic [urg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [urg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import urg_pkg::*;

    dp_cmd_t cmd;

    // sequencer
    urg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd)
    );

    // generator, multiplier and remainder unit
    urg_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .last_request  (req.last_request),
        .source_vertex (res.source_vertex),
        .dest_vertex   (res.dest_vertex),
        .edge_valid    (res.edge_valid),
        .batch_done    (res.batch_done),
        .state_after   (res.state_after)
    );

`ifndef SYNTH
    // one item at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while an item is in progress");

    // output register never overwritten before its transfer
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_LOAD_OUT) |-> (!res.valid || res.ready))
        else $error("result overwritten before transfer");

    // self-loop flag follows the vertices
    a_edge_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.edge_valid == (res.source_vertex != res.dest_vertex)))
        else $error("edge_valid does not match vertices");
`endif

endmodule

`default_nettype wire
